### rtl/mf3_pkg.sv
// Shared types, register codes and compare helpers for the 3x3 median filter.
`timescale 1ns / 1ps
package mf3_pkg;

	typedef logic [7:0] pix_t;

	typedef struct packed {
		pix_t upper;
		pix_t lower;
	} line_word_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	function automatic pix_t pix_min(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t pix_max(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

### rtl/median_filter_square_3x3.sv
// Top level of the 3x3 median filter: position counters, window and output register.
// Each beat is registered with its line-memory read, then its result in the output register.
// One beat per cycle unless the output stalls; line memory read and written once per beat.
// Results trail the input by one row plus one pixel; drain beats push out the last row.
// Reset clears the counters, the window and the valid flags; the line memory is not cleared.
`timescale 1ns / 1ps
module median_filter_square_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  median,
	output logic        frame_end
);

	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(MAX_WIDTH);
	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam logic [13:0] MW14 = 14'(MAX_WIDTH);

	typedef struct packed {
		logic [AW-1:0] addr;
		logic [CW-1:0] ch;
		logic          px0;
		logic          px1;
		logic          top_rep;
		logic          bot_rep;
		logic          emit;
		logic          last;
		pix_t          value;
	} s1_t;

	logic [PW-1:0] w_last_q;
	logic [15:0]   h_q;
	logic [CW-1:0] cc_last_q;

	logic [AW-1:0] in_col_q;
	logic [PW-1:0] px_q;
	logic [CW-1:0] ch_q;
	logic [16:0]   in_row_q;
	logic [PW-1:0] out_px_q;
	logic [CW-1:0] out_ch_q;
	logic [15:0]   out_row_q;

	logic          s1_valid_q;
	s1_t           s1_q;
	logic          out_valid_q;
	pix_t          median_q;
	logic          frame_end_q;

	pix_t          win_q [MAX_CHANNELS][2][3];

	logic          acc;
	logic          in_frame;
	logic          step;
	logic          emit_0;
	logic          top_rep_0;
	logic          bot_rep_0;
	logic          last_0;
	logic          col_wrap;
	logic          out_wrap;
	logic          cfg_known;
	logic          s1_go;
	line_word_t    rd_word;
	line_word_t    wr_word;
	pix_t          nw [3];
	pix_t          win [9];
	pix_t          med;

	logic [13:0]   cfg_w;
	logic [PW-1:0] w_next;
	logic [CW-1:0] cc_next;
	logic [15:0]   h_next;

	assign cfg_ready = 1'b1;
	assign cfg_known = (cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)
		|| (cfg_index == REG_CHANNEL_COUNT);

	assign s1_go    = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign in_frame = in_row_q < {1'b0, h_q};
	assign step     = acc && !(command == CMD_DRAIN && in_frame);

	assign emit_0    = (in_row_q != '0) && ((px_q != '0) || (in_row_q > 17'd1));
	assign top_rep_0 = (out_row_q == '0);
	assign bot_rep_0 = ({1'b0, out_row_q} + 17'd1) >= {1'b0, h_q};
	assign col_wrap  = (px_q == w_last_q) && (ch_q == cc_last_q);
	assign out_wrap  = (out_px_q == w_last_q) && (out_ch_q == cc_last_q);
	assign last_0    = bot_rep_0 && out_wrap;

	always_comb begin
		cfg_w = {2'b00, cfg_data[11:0]};
		if (cfg_w < 14'd2) begin
			w_next = PW'(1);
		end else if (cfg_w > MW14) begin
			w_next = PW'(MAX_WIDTH - 1);
		end else begin
			w_next = PW'(cfg_w - 14'd1);
		end
		if (cfg_data[2:0] == 3'd0) begin
			cc_next = '0;
		end else if (cfg_data[2:0] > 3'(MAX_CHANNELS)) begin
			cc_next = CW'(MAX_CHANNELS - 1);
		end else begin
			cc_next = CW'(cfg_data[2:0] - 3'd1);
		end
		h_next = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q  <= PW'(W_RST - 1);
			h_q       <= 16'd480;
			cc_last_q <= '0;
			in_col_q  <= '0;
			px_q      <= '0;
			ch_q      <= '0;
			in_row_q  <= '0;
			out_px_q  <= '0;
			out_ch_q  <= '0;
			out_row_q <= '0;
		end else if (cfg_valid && cfg_known) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: w_last_q <= w_next;
				REG_IMAGE_HEIGHT: h_q <= h_next;
				REG_CHANNEL_COUNT: cc_last_q <= cc_next;
				default: ;
			endcase
			in_col_q  <= '0;
			px_q      <= '0;
			ch_q      <= '0;
			in_row_q  <= '0;
			out_px_q  <= '0;
			out_ch_q  <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (emit_0 && last_0) begin
				in_col_q  <= '0;
				px_q      <= '0;
				ch_q      <= '0;
				in_row_q  <= '0;
				out_px_q  <= '0;
				out_ch_q  <= '0;
				out_row_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					px_q     <= '0;
					ch_q     <= '0;
					in_row_q <= in_row_q + 17'd1;
				end else begin
					in_col_q <= in_col_q + AW'(1);
					if (ch_q == cc_last_q) begin
						ch_q <= '0;
						px_q <= px_q + PW'(1);
					end else begin
						ch_q <= ch_q + CW'(1);
					end
				end
				if (emit_0) begin
					if (out_wrap) begin
						out_px_q  <= '0;
						out_ch_q  <= '0;
						out_row_q <= out_row_q + 16'd1;
					end else if (out_ch_q == cc_last_q) begin
						out_ch_q <= '0;
						out_px_q <= out_px_q + PW'(1);
					end else begin
						out_ch_q <= out_ch_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			s1_q.addr    <= in_col_q;
			s1_q.ch      <= ch_q;
			s1_q.px0     <= (px_q == '0);
			s1_q.px1     <= (px_q == PW'(1));
			s1_q.top_rep <= top_rep_0;
			s1_q.bot_rep <= bot_rep_0;
			s1_q.emit    <= emit_0;
			s1_q.last    <= last_0;
			s1_q.value   <= in_frame ? sample : 8'd0;
		end
	end

	assign wr_word.upper = rd_word.lower;
	assign wr_word.lower = s1_q.value;

	mf3_line_buf #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_line_buf (
		.clk(clk),
		.rd_en(step),
		.rd_addr(in_col_q),
		.rd_data(rd_word),
		.wr_en(s1_go),
		.wr_addr(s1_q.addr),
		.wr_data(wr_word)
	);

	// Window columns feeding the network: the older and newer stored columns and the
	// column that arrives with this beat; at the left and right edges the centre column repeats.
	always_comb begin
		pix_t cols [3][3];
		pix_t o1 [3];
		pix_t o2 [3];
		nw[0] = rd_word.upper;
		nw[1] = rd_word.lower;
		nw[2] = s1_q.value;
		o1 = win_q[s1_q.ch][0];
		o2 = win_q[s1_q.ch][1];
		if (s1_q.px0) begin
			cols[0] = o1;
			cols[1] = o2;
			cols[2] = o2;
		end else if (s1_q.px1) begin
			cols[0] = o2;
			cols[1] = o2;
			cols[2] = nw;
		end else begin
			cols[0] = o1;
			cols[1] = o2;
			cols[2] = nw;
		end
		for (int k = 0; k < 3; k++) begin
			win[k]     = s1_q.top_rep ? cols[k][1] : cols[k][0];
			win[3 + k] = cols[k][1];
			win[6 + k] = s1_q.bot_rep ? cols[k][1] : cols[k][2];
		end
	end

	mf3_median9 u_median9 (
		.win(win),
		.med(med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				for (int j = 0; j < 2; j++) begin
					for (int r = 0; r < 3; r++) begin
						win_q[c][j][r] <= '0;
					end
				end
			end
		end else if (s1_go) begin
			win_q[s1_q.ch][0] <= win_q[s1_q.ch][1];
			win_q[s1_q.ch][1] <= nw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_q.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_q.emit) begin
			median_q    <= med;
			frame_end_q <= s1_q.last;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign frame_end = frame_end_q;

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_q <= cc_last_q) && (px_q <= w_last_q))
		else $error("input position beyond the configured row");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q < h_q)
		else $error("output row beyond the frame");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= ({1'b0, h_q} + 17'd1))
		else $error("drain ran past the end of the frame");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit_0 && last_0) |=> (in_row_q == '0) && (out_row_q == '0) && (px_q == '0))
		else $error("counters did not restart after the last beat of the frame");

endmodule

### rtl/mf3_line_buf.sv
// Line memory holding the two previous rows, one word per sample position.
`timescale 1ns / 1ps
module mf3_line_buf import mf3_pkg::*; #(
	parameter int DEPTH = 8192,
	parameter int AW = 13
) (
	input  logic       clk,
	input  logic       rd_en,
	input  logic [AW-1:0] rd_addr,
	output line_word_t rd_data,
	input  logic       wr_en,
	input  logic [AW-1:0] wr_addr,
	input  line_word_t wr_data
);

	line_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

### rtl/mf3_median9.sv
// Partial sorting network that picks the median of nine samples.
`timescale 1ns / 1ps
module mf3_median9 import mf3_pkg::*; (
	input  pix_t win [9],
	output pix_t med
);

	always_comb begin
		pix_t t [9];
		t = win;
		{t[1], t[2]} = {pix_min(t[1], t[2]), pix_max(t[1], t[2])};
		{t[4], t[5]} = {pix_min(t[4], t[5]), pix_max(t[4], t[5])};
		{t[7], t[8]} = {pix_min(t[7], t[8]), pix_max(t[7], t[8])};
		{t[0], t[1]} = {pix_min(t[0], t[1]), pix_max(t[0], t[1])};
		{t[3], t[4]} = {pix_min(t[3], t[4]), pix_max(t[3], t[4])};
		{t[6], t[7]} = {pix_min(t[6], t[7]), pix_max(t[6], t[7])};
		{t[1], t[2]} = {pix_min(t[1], t[2]), pix_max(t[1], t[2])};
		{t[4], t[5]} = {pix_min(t[4], t[5]), pix_max(t[4], t[5])};
		{t[7], t[8]} = {pix_min(t[7], t[8]), pix_max(t[7], t[8])};
		t[3] = pix_max(t[0], t[3]);
		t[5] = pix_min(t[5], t[8]);
		{t[4], t[7]} = {pix_min(t[4], t[7]), pix_max(t[4], t[7])};
		t[6] = pix_max(t[3], t[6]);
		t[4] = pix_max(t[1], t[4]);
		t[2] = pix_min(t[2], t[5]);
		t[4] = pix_min(t[4], t[7]);
		{t[4], t[2]} = {pix_min(t[4], t[2]), pix_max(t[4], t[2])};
		t[4] = pix_max(t[6], t[4]);
		med  = pix_min(t[4], t[2]);
	end

endmodule
